>>> rtl/bssc_pkg.sv
package bssc_pkg;

    // Event codes carried on the opcode field.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ZC    = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_UP    = 3'd3;
    localparam logic [2:0] OP_DOWN  = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_START_DUTY  = 3'd0;
    localparam logic [2:0] REG_DUTY_MIN    = 3'd1;
    localparam logic [2:0] REG_DUTY_MAX    = 3'd2;
    localparam logic [2:0] REG_RAMP_START  = 3'd3;
    localparam logic [2:0] REG_RAMP_END    = 3'd4;
    localparam logic [2:0] REG_ALIGN_TICKS = 3'd5;
    localparam logic [2:0] REG_STALL_LIMIT = 3'd6;

    localparam int  ADDR_W = 5;
    localparam int  DATA_W = 32;

    // Phase codes for the sense output.
    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_C = 2'd2;

    localparam logic [2:0]  STEP_LAST = 3'd5;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    // x / 15 for 16-bit x equals (x * 0x8889) >> 19.
    localparam logic [15:0] DIV15_RECIP = 16'h8889;
    localparam int          DIV15_SHIFT = 19;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0]  start_duty;
        logic [7:0]  duty_min;
        logic [7:0]  duty_max;
        logic [15:0] ramp_start;
        logic [15:0] ramp_end;
        logic [15:0] align_ticks;
        logic [15:0] stall_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_duty:  8'd20,
        duty_min:    8'd10,
        duty_max:    8'd250,
        ramp_start:  16'd300,
        ramp_end:    16'd25,
        align_ticks: 16'd100,
        stall_limit: 16'd449
    };

    typedef struct packed {
        logic [2:0]  step;
        logic [7:0]  duty_setting;
        logic [7:0]  applied_duty;
        t_mode       mode;
        logic        aligning;
        logic [15:0] ramp_interval;
        logic [15:0] tick_count;
        logic [15:0] stall_count;
    } t_state;

    localparam t_state STATE_RESET = '{
        step:          3'd0,
        duty_setting:  8'd0,
        applied_duty:  8'd0,
        mode:          MODE_STOPPED,
        aligning:      1'b0,
        ramp_interval: 16'd0,
        tick_count:    16'd0,
        stall_count:   16'd0
    };

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] duty_c;
        logic       low_a;
        logic       low_b;
        logic       low_c;
        logic [1:0] sense_phase;
        logic       sense_falling;
        t_mode      mode;
        logic [2:0] step;
    } t_drive;

endpackage

>>> rtl/bssc_regs.sv
module bssc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bssc_pkg::DATA_W-1:0]   pwdata,
    output logic [bssc_pkg::DATA_W-1:0]   prdata,
    output bssc_pkg::t_cfg                o_cfg
);
    import bssc_pkg::*;

    t_cfg        r_cfg;
    logic        w_wr;
    logic [2:0]  w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_START_DUTY:  r_cfg.start_duty  <= pwdata[7:0];
                REG_DUTY_MIN:    r_cfg.duty_min    <= pwdata[7:0];
                REG_DUTY_MAX:    r_cfg.duty_max    <= pwdata[7:0];
                REG_RAMP_START:  r_cfg.ramp_start  <= pwdata[15:0];
                REG_RAMP_END:    r_cfg.ramp_end    <= pwdata[15:0];
                REG_ALIGN_TICKS: r_cfg.align_ticks <= pwdata[15:0];
                REG_STALL_LIMIT: r_cfg.stall_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_START_DUTY:  prdata = {24'd0, r_cfg.start_duty};
            REG_DUTY_MIN:    prdata = {24'd0, r_cfg.duty_min};
            REG_DUTY_MAX:    prdata = {24'd0, r_cfg.duty_max};
            REG_RAMP_START:  prdata = {16'd0, r_cfg.ramp_start};
            REG_RAMP_END:    prdata = {16'd0, r_cfg.ramp_end};
            REG_ALIGN_TICKS: prdata = {16'd0, r_cfg.align_ticks};
            REG_STALL_LIMIT: prdata = {16'd0, r_cfg.stall_limit};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/bssc_core.sv
module bssc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [2:0]       i_opcode,
    input  logic             i_from_button,
    input  bssc_pkg::t_cfg   i_cfg,
    output bssc_pkg::t_state o_next
);
    import bssc_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [31:0] w_prod;
    logic [15:0] w_dec;
    logic [15:0] w_ramp_next;
    logic [15:0] w_tick_inc;
    logic [15:0] w_stall_inc;

    function automatic t_state begin_start(t_state s, t_cfg c);
        t_state r;
        r               = s;
        r.duty_setting  = c.start_duty;
        r.step          = 3'd0;
        r.applied_duty  = c.start_duty;
        r.mode          = MODE_STARTING;
        r.aligning      = 1'b1;
        r.ramp_interval = c.ramp_start;
        r.tick_count    = 16'd0;
        r.stall_count   = 16'd0;
        return r;
    endfunction

    function automatic t_state halt(t_state s);
        t_state r;
        r             = s;
        r.mode        = MODE_STOPPED;
        r.aligning    = 1'b0;
        r.tick_count  = 16'd0;
        r.stall_count = 16'd0;
        return r;
    endfunction

    function automatic t_state advance(t_state s);
        t_state r;
        r              = s;
        r.step         = (s.step >= STEP_LAST) ? 3'd0 : s.step + 3'd1;
        r.applied_duty = s.duty_setting;
        return r;
    endfunction

    // Ramp shrink: interval - (interval / 15 + 1), floored at zero.
    assign w_prod      = r_state.ramp_interval * DIV15_RECIP;
    assign w_dec       = {3'd0, w_prod[31:DIV15_SHIFT]} + 16'd1;
    assign w_ramp_next = (w_dec > r_state.ramp_interval) ? 16'd0
                                                         : r_state.ramp_interval - w_dec;
    assign w_tick_inc  = (r_state.tick_count == CNT_MAX) ? CNT_MAX
                                                         : r_state.tick_count + 16'd1;
    assign w_stall_inc = (r_state.stall_count == CNT_MAX) ? CNT_MAX
                                                          : r_state.stall_count + 16'd1;

    always_comb begin
        n_state = r_state;
        case (i_opcode)
            OP_TICK: begin
                if (r_state.mode == MODE_STARTING) begin
                    n_state.tick_count = w_tick_inc;
                    if (r_state.aligning) begin
                        if (w_tick_inc >= i_cfg.align_ticks) begin
                            n_state.aligning   = 1'b0;
                            n_state.tick_count = 16'd0;
                        end
                    end else if (w_tick_inc >= r_state.ramp_interval) begin
                        n_state.tick_count    = 16'd0;
                        n_state.ramp_interval = w_ramp_next;
                        if (w_ramp_next < i_cfg.ramp_end) begin
                            n_state.mode        = MODE_RUNNING;
                            n_state.stall_count = 16'd0;
                        end else begin
                            n_state = advance(n_state);
                        end
                    end
                end else if (r_state.mode == MODE_RUNNING) begin
                    n_state.stall_count = w_stall_inc;
                    if (w_stall_inc >= i_cfg.stall_limit) begin
                        n_state = begin_start(n_state, i_cfg);
                    end
                end
            end
            OP_ZC: begin
                if (r_state.mode == MODE_RUNNING) begin
                    n_state.stall_count = 16'd0;
                    n_state = advance(n_state);
                end
            end
            OP_START: begin
                n_state = begin_start(r_state, i_cfg);
            end
            OP_UP: begin
                if (i_from_button && r_state.mode == MODE_STOPPED) begin
                    n_state = begin_start(r_state, i_cfg);
                end else if (r_state.duty_setting < i_cfg.duty_max) begin
                    n_state.duty_setting = r_state.duty_setting + 8'd1;
                end
            end
            OP_DOWN: begin
                if (r_state.duty_setting > i_cfg.duty_min) begin
                    n_state.duty_setting = r_state.duty_setting - 8'd1;
                end else if (i_from_button) begin
                    n_state = halt(r_state);
                end
            end
            OP_STOP: begin
                n_state = halt(r_state);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule

>>> rtl/bssc_drive.sv
module bssc_drive (
    input  bssc_pkg::t_state i_state,
    output bssc_pkg::t_drive o_drive
);
    import bssc_pkg::*;

    logic [2:0] w_step;
    logic [1:0] w_hi;
    logic [1:0] w_lo;
    logic       w_on;

    assign w_step = (i_state.step <= STEP_LAST) ? i_state.step : 3'd0;
    assign w_on   = (i_state.mode != MODE_STOPPED);

    // Steps in order: AB, AC, BC, BA, CA, CB; the sensed phase is the third one.
    always_comb begin
        case (w_step)
            3'd0:    begin w_hi = PHASE_A; w_lo = PHASE_B; o_drive.sense_phase = PHASE_C; end
            3'd1:    begin w_hi = PHASE_A; w_lo = PHASE_C; o_drive.sense_phase = PHASE_B; end
            3'd2:    begin w_hi = PHASE_B; w_lo = PHASE_C; o_drive.sense_phase = PHASE_A; end
            3'd3:    begin w_hi = PHASE_B; w_lo = PHASE_A; o_drive.sense_phase = PHASE_C; end
            3'd4:    begin w_hi = PHASE_C; w_lo = PHASE_A; o_drive.sense_phase = PHASE_B; end
            default: begin w_hi = PHASE_C; w_lo = PHASE_B; o_drive.sense_phase = PHASE_A; end
        endcase
        o_drive.duty_a        = (w_on && w_hi == PHASE_A) ? i_state.applied_duty : 8'd0;
        o_drive.duty_b        = (w_on && w_hi == PHASE_B) ? i_state.applied_duty : 8'd0;
        o_drive.duty_c        = (w_on && w_hi == PHASE_C) ? i_state.applied_duty : 8'd0;
        o_drive.low_a         = w_on && (w_lo == PHASE_A);
        o_drive.low_b         = w_on && (w_lo == PHASE_B);
        o_drive.low_c         = w_on && (w_lo == PHASE_C);
        o_drive.sense_falling = ~w_step[0];
        o_drive.mode          = i_state.mode;
        o_drive.step          = i_state.step;
    end

endmodule

>>> rtl/bldc_sensorless_six_step_commutator_top.sv
// Six-step sensorless BLDC commutation controller.
// Input channel (i_in_valid / o_in_ready) carries one event per beat: tick,
// zero crossing, start, speed up, speed down or stop, plus a button flag.
// Output channel (o_out_valid / i_out_ready) returns exactly one drive beat
// per event: phase duties, low-side enables, sensed phase and edge, mode
// and commutation step, all as they stand after the event.
// The result beat appears in the cycle after its event is accepted. A new
// event is taken every cycle while the output is free or being consumed;
// the combinational next-state path, whose longest arm is the 16x16
// reciprocal multiply for the ramp shrink, sets that rate.
// If the receiver stalls, the result stays in the output register and the
// input is taken again in the same cycle that the result is consumed.
// Reset (synchronous, active low) stops the motor, clears all counters and
// loads the register defaults. Registers are written through the APB port
// at byte address 4*index, one write per access cycle, pready always high.
module bldc_sensorless_six_step_commutator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bssc_pkg::DATA_W-1:0]   pwdata,
    output logic [bssc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_opcode,
    input  logic                          i_from_button,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_duty_a,
    output logic [7:0]                    o_duty_b,
    output logic [7:0]                    o_duty_c,
    output logic                          o_low_a,
    output logic                          o_low_b,
    output logic                          o_low_c,
    output logic [1:0]                    o_sense_phase,
    output logic                          o_sense_falling,
    output logic [1:0]                    o_motor_mode,
    output logic [2:0]                    o_commutation_step
);
    import bssc_pkg::*;

    t_cfg   w_cfg;
    t_state w_next;
    t_drive w_drive;
    t_drive r_drive;
    logic   r_out_valid;
    logic   w_accept;

    assign pready     = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    bssc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    bssc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_opcode      (i_opcode),
        .i_from_button (i_from_button),
        .i_cfg         (w_cfg),
        .o_next        (w_next)
    );

    bssc_drive u_drive (
        .i_state (w_next),
        .o_drive (w_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drive <= w_drive;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_duty_a           = r_drive.duty_a;
    assign o_duty_b           = r_drive.duty_b;
    assign o_duty_c           = r_drive.duty_c;
    assign o_low_a            = r_drive.low_a;
    assign o_low_b            = r_drive.low_b;
    assign o_low_c            = r_drive.low_c;
    assign o_sense_phase      = r_drive.sense_phase;
    assign o_sense_falling    = r_drive.sense_falling;
    assign o_motor_mode       = r_drive.mode;
    assign o_commutation_step = r_drive.step;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted event produced no result beat");

    a_stopped_drive_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_motor_mode == MODE_STOPPED) |->
        (o_duty_a == 8'd0 && o_duty_b == 8'd0 && o_duty_c == 8'd0 &&
         !o_low_a && !o_low_b && !o_low_c))
        else $error("drive active while stopped");

    a_one_low_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_motor_mode != MODE_STOPPED) |->
        $onehot({o_low_a, o_low_b, o_low_c}))
        else $error("low-side enables not exactly one while driving");

    a_sense_not_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        !((o_sense_phase == PHASE_A && (o_low_a || o_duty_a != 8'd0)) ||
          (o_sense_phase == PHASE_B && (o_low_b || o_duty_b != 8'd0)) ||
          (o_sense_phase == PHASE_C && (o_low_c || o_duty_c != 8'd0))))
        else $error("sensed phase is being driven");

endmodule
